### src/bcs_pkg.sv
// shared types and constants for the battery capacity smoother
package bcs_pkg;

	localparam int CAP_W  = 7;
	localparam int STAT_W = 3;
	localparam int TIME_W = 32;
	localparam int NUM_W  = 14;
	localparam int FP_W   = 8;

	localparam logic [FP_W-1:0]   FULL_POINT_MAX = 8'd125;
	localparam logic [FP_W-1:0]   FULL_POINT_SAT = 8'd127;
	localparam logic [CAP_W-1:0]  NONE_YET       = 7'd101;
	localparam logic [CAP_W-1:0]  CAP_FULL       = 7'd100;
	localparam logic [CAP_W-1:0]  FULL_POINT_RST = 7'd98;
	localparam logic [CAP_W-1:0]  FULL_LIMIT_RST = 7'd80;
	localparam logic [TIME_W-1:0] MIN_PERIOD     = 32'd60;

	// charge status codes
	localparam logic [STAT_W-1:0] STAT_CHARGING    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_DISCHARGING = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_CHARGING = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL        = 3'd4;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [CAP_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

### src/bcs_div.sv
// shared restoring divider, one quotient bit a cycle, rounds half up
module bcs_div (
	input  logic            clk,
	input  logic            arst_n,
	input  bcs_pkg::div_req_t req,
	output bcs_pkg::div_rsp_t rsp
);
	import bcs_pkg::*;

	logic [NUM_W-1:0] quo_q;
	logic [CAP_W-1:0] rem_q;
	logic [CAP_W-1:0] den_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CAP_W:0]   trial;
	logic             fits;
	logic             round_up;

	// one restoring step
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? CAP_W'(trial - {1'b0, den_q}) : trial[CAP_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	// half-up rounding on the final remainder
	assign round_up = {1'b0, rem_q, 1'b0} >= {2'b00, den_q};
	assign rsp.done = done_q;
	assign rsp.quot = quo_q + NUM_W'(round_up);

endmodule

### src/battery_capacity_smoother.sv
// battery capacity smoother top level: sequencer, state and config port
// Each report is taken when in_ready is high and yields one beat of shown_capacity.
// All scaling runs through one shared 14-bit restoring divider. A report with no search
// needs at most one division; a full-point search runs one division per candidate
// full point, up to 127. In fake mode a report uses no division at all.
// A finished beat waits in an output register, so the next report can be taken
// while it is still unread.
module battery_capacity_smoother (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  raw_capacity,
	input  logic [2:0]  charge_status,
	input  logic        health_good,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  shown_capacity,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bcs_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_PRE     = 4'd1;
	localparam logic [3:0] S_SRCH    = 4'd2;
	localparam logic [3:0] S_SRCH_W  = 4'd3;
	localparam logic [3:0] S_SCALE   = 4'd4;
	localparam logic [3:0] S_SCALE_W = 4'd5;
	localparam logic [3:0] S_FIN1    = 4'd6;
	localparam logic [3:0] S_FIN2    = 4'd7;
	localparam logic [3:0] S_OUT     = 4'd8;

	localparam logic [1:0] SM_NONE = 2'd0;
	localparam logic [1:0] SM_UP   = 2'd1;
	localparam logic [1:0] SM_DOWN = 2'd2;

	localparam logic [1:0] CHG_NONE   = 2'd0;
	localparam logic [1:0] CHG_TO_CHG = 2'd1;
	localparam logic [1:0] CHG_TO_DIS = 2'd2;

	localparam logic REG_FULL_LIMIT = 1'b0;
	localparam logic REG_FAKE       = 1'b1;

	logic [3:0]        state_q;
	logic [CAP_W-1:0]  full_limit_q;
	logic              fake_q;
	logic [CAP_W-1:0]  cap_q;
	logic [STAT_W-1:0] status_q;
	logic              health_q;
	logic [TIME_W-1:0] now_q;

	logic [CAP_W-1:0]  full_point_q;
	logic [STAT_W-1:0] prev_status_q;
	logic [1:0]        smooth_q;
	logic [CAP_W-1:0]  prev_gauge_q;
	logic [TIME_W-1:0] gauge_time_q;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] step_time_q;
	logic [CAP_W-1:0]  prev_shown_q;

	logic [TIME_W-1:0] elapsed_q;
	logic [FP_W-1:0]   t_q;
	logic              search_up_q;
	logic [CAP_W-1:0]  newcap_q;
	logic [CAP_W-1:0]  last_q;
	logic [CAP_W-1:0]  ret_q;
	logic              out_valid_q;
	logic [CAP_W-1:0]  shown_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              cfg_wr;
	logic [CAP_W-1:0]  fp_upd;
	logic [1:0]        change;
	logic              was_chg, was_dis, is_dis;
	logic [CAP_W-1:0]  lo_bound;
	logic [TIME_W-1:0] elapsed_d;
	logic [NUM_W-1:0]  num;
	logic [CAP_W-1:0]  last_d;
	logic [TIME_W-1:0] period_d;
	logic              slow_ok;
	logic [CAP_W-1:0]  delta;
	logic [CAP_W-1:0]  ret_d;
	logic [1:0]        smooth_d;
	logic [CAP_W-1:0]  fp_dec;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_limit_q <= FULL_LIMIT_RST;
			fake_q       <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FULL_LIMIT: full_limit_q <= pwdata[CAP_W-1:0];
				REG_FAKE:       fake_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FULL_LIMIT: prdata = {25'd0, full_limit_q};
			REG_FAKE:       prdata = {31'd0, fake_q};
			default:        prdata = '0;
		endcase
	end

	// shared divider
	assign num = ({1'b0, cap_q, 6'd0} + {2'b00, cap_q, 5'd0}) + {5'd0, cap_q, 2'd0};
	bcs_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	always_comb begin
		div_req.num   = num;
		div_req.den   = (state_q == S_SRCH) ? t_q[CAP_W-1:0] : full_point_q;
		div_req.start = 1'b0;
		if (state_q == S_SRCH) begin
			div_req.start = search_up_q ? (t_q <= FULL_POINT_MAX)
			                            : (t_q >= {1'b0, lo_bound});
		end else if (state_q == S_SCALE) begin
			div_req.start = cap_q < full_point_q;
		end
	end

	// full-point capture and direction change
	always_comb begin
		fp_upd = full_point_q;
		if ((status_q == STAT_FULL || (cap_q > full_point_q && cap_q != CAP_FULL))
		    && health_q && cap_q > full_limit_q)
			fp_upd = cap_q;
		was_chg = prev_status_q == STAT_CHARGING || prev_status_q == STAT_FULL;
		was_dis = prev_status_q == STAT_DISCHARGING || prev_status_q == STAT_NOT_CHARGING;
		is_dis  = status_q == STAT_DISCHARGING || status_q == STAT_NOT_CHARGING;
		change  = CHG_NONE;
		if (prev_status_q != status_q) begin
			if (was_chg && is_dis)
				change = CHG_TO_DIS;
			else if (was_dis && status_q == STAT_CHARGING)
				change = CHG_TO_CHG;
		end
		fp_dec   = (fp_upd > 7'd1) ? fp_upd - 7'd1 : 7'd1;
		lo_bound = (full_limit_q == '0) ? 7'd1 : full_limit_q;
	end

	// elapsed time for this report
	always_comb begin
		if (now_q >= gauge_time_q)
			elapsed_d = (prev_gauge_q != cap_q) ? now_q - gauge_time_q : now_q - step_time_q;
		else
			elapsed_d = MIN_PERIOD;
	end

	// gauge period and first shown value
	always_comb begin
		last_d   = (prev_shown_q == NONE_YET) ? newcap_q : prev_shown_q;
		period_d = period_q;
		if (prev_gauge_q != NONE_YET && elapsed_q != '0)
			period_d = elapsed_q;
		if (period_d < MIN_PERIOD)
			period_d = MIN_PERIOD;
	end

	// one-step move of the shown value
	always_comb begin
		slow_ok  = elapsed_q >= (period_q >> 1);
		delta    = (newcap_q > last_q) ? newcap_q - last_q : last_q - newcap_q;
		smooth_d = smooth_q;
		ret_d    = last_q;
		if (status_q == STAT_DISCHARGING && newcap_q > last_q) begin
			ret_d = last_q;
		end else if (delta == 7'd1) begin
			if (smooth_q == SM_NONE) begin
				ret_d = newcap_q;
			end else if (slow_ok) begin
				smooth_d = SM_NONE;
				ret_d    = newcap_q;
			end
		end else if (delta > 7'd1) begin
			if (smooth_q == SM_NONE) begin
				smooth_d = (newcap_q > last_q) ? SM_UP : SM_DOWN;
				ret_d    = (newcap_q > last_q) ? last_q + 7'd1 : last_q - 7'd1;
			end else if (slow_ok) begin
				ret_d = (newcap_q > last_q) ? last_q + 7'd1 : last_q - 7'd1;
			end
		end else begin
			smooth_d = SM_NONE;
			ret_d    = newcap_q;
		end
		if (ret_d > CAP_FULL)
			ret_d = CAP_FULL;
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			full_point_q  <= FULL_POINT_RST;
			prev_status_q <= '0;
			smooth_q      <= SM_NONE;
			prev_gauge_q  <= NONE_YET;
			gauge_time_q  <= '0;
			period_q      <= MIN_PERIOD;
			step_time_q   <= '0;
			prev_shown_q  <= NONE_YET;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= fake_q ? S_OUT : S_PRE;
				end
				S_PRE: begin
					prev_status_q <= status_q;
					if (smooth_q == SM_UP && change == CHG_TO_DIS) begin
						full_point_q <= fp_upd;
						state_q      <= S_SRCH;
					end else if (smooth_q == SM_DOWN && change == CHG_TO_CHG) begin
						full_point_q <= fp_upd;
						state_q      <= S_SRCH;
					end else begin
						if (smooth_q == SM_NONE && change == CHG_TO_DIS && prev_shown_q == CAP_FULL)
							full_point_q <= fp_dec;
						else
							full_point_q <= fp_upd;
						state_q <= S_SCALE;
					end
				end
				S_SRCH: begin
					if (div_req.start)
						state_q <= S_SRCH_W;
					else begin
						if (search_up_q)
							full_point_q <= (t_q > FULL_POINT_SAT) ? FULL_POINT_SAT[CAP_W-1:0]
							                                      : t_q[CAP_W-1:0];
						else
							full_point_q <= (t_q == '0) ? 7'd1 : t_q[CAP_W-1:0];
						state_q <= S_SCALE;
					end
				end
				S_SRCH_W: begin
					if (div_rsp.done) begin
						if (search_up_q ? (div_rsp.quot <= NUM_W'(prev_shown_q))
						                : (div_rsp.quot >= NUM_W'(prev_shown_q))) begin
							full_point_q <= t_q[CAP_W-1:0];
							state_q      <= S_SCALE;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SCALE: begin
					state_q <= div_req.start ? S_SCALE_W : S_FIN1;
				end
				S_SCALE_W: begin
					if (div_rsp.done)
						state_q <= S_FIN1;
				end
				S_FIN1: begin
					prev_shown_q <= last_d;
					if (prev_gauge_q != cap_q && status_q != STAT_FULL) begin
						period_q     <= period_d;
						prev_gauge_q <= cap_q;
						gauge_time_q <= now_q;
					end
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					smooth_q <= smooth_d;
					if (last_q != ret_d) begin
						prev_shown_q <= ret_d;
						step_time_q  <= now_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cap_q    <= raw_capacity;
			status_q <= charge_status;
			health_q <= health_good;
			now_q    <= now_seconds;
			ret_q    <= raw_capacity;
		end
		if (state_q == S_PRE) begin
			elapsed_q   <= elapsed_d;
			t_q         <= {1'b0, fp_upd};
			search_up_q <= smooth_q == SM_UP;
		end
		if (state_q == S_SRCH_W && div_rsp.done)
			t_q <= search_up_q ? t_q + 8'd1 : t_q - 8'd1;
		if (state_q == S_SCALE && !div_req.start)
			newcap_q <= CAP_FULL;
		if (state_q == S_SCALE_W && div_rsp.done)
			newcap_q <= (div_rsp.quot > NUM_W'(CAP_FULL)) ? CAP_FULL : div_rsp.quot[CAP_W-1:0];
		if (state_q == S_FIN1)
			last_q <= last_d;
		if (state_q == S_FIN2)
			ret_q <= ret_d;
		if (state_q == S_OUT && (!out_valid_q || out_ready))
			shown_q <= ret_q;
	end

	assign in_ready       = state_q == S_IDLE;
	assign out_valid      = out_valid_q;
	assign shown_capacity = shown_q;

endmodule

### src/bcs_checker.sv
// port-level checks for the battery capacity smoother
module bcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  shown_capacity,
	input logic        pready
);
	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shown_capacity))
		else $error("result beat dropped or changed while stalled");

	// the block is busy right after taking a report
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("report taken while a previous one is in work");

	// every report finishes before a new one is taken, so a beat shows up between
	a_result_between: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 !in_ready |=> !in_ready || out_valid || $past(out_valid))
		else $error("report finished without a result beat");

	// config port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port stalled");

endmodule

bind battery_capacity_smoother bcs_checker u_bcs_checker (.*);

### tb/tb_top.sv
// self-checking testbench for the battery capacity smoother
`timescale 1ns / 1ps

module tb_top;
	import bcs_pkg::*;

	localparam int REG_FULL_LIMIT = 0;
	localparam int REG_FAKE_EN    = 1;
	localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_UNUSED_LO = 3'd5;
	localparam logic [STAT_W-1:0] STAT_UNUSED_HI = 3'd7;
	localparam int NO_TYPED    = -1;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [6:0]  raw_capacity = 0;
	logic [2:0]  charge_status = 0;
	logic        health_good = 0;
	logic [31:0] now_seconds = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [6:0]  shown_capacity;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	battery_capacity_smoother u_dut (.*);

	always #5 clk = ~clk;

	// model state and config shadow
	int        cfg_full_limit, cfg_fake_en;
	int        full_pt, last_status, smooth_dir, gauge_cap_seen, last_shown;
	bit [31:0] gauge_time, gauge_period, step_stamp;

	logic [6:0] shown_q[$];
	int         typed_shown = NO_TYPED;
	int         errors = 0;
	int         in_beats = 0;
	bit         calm = 0, hold_req = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int scale_round(input int cap, input int den);
		int num, q;
		num = cap * 100;
		q = num / den;
		if ((num % den) * 2 >= den) q++;
		return q;
	endfunction

	// compute the shown capacity for one report and advance the model
	function automatic int predict_shown(input int cap, input int status, input int health,
			input bit [31:0] now);
		int  dir_change, t, lo, newcap, last, delta, ret;
		bit  hit;
		bit  was_chg, was_dis, is_dis;
		bit [31:0] elapsed;
		dir_change = 0;
		if (cfg_fake_en) return cap;
		if ((status == STAT_FULL || (cap > full_pt && cap != 100)) && health
				&& cap > cfg_full_limit)
			full_pt = cap;
		if (last_status != status) begin
			was_chg = (last_status == STAT_CHARGING || last_status == STAT_FULL);
			was_dis = (last_status == STAT_DISCHARGING || last_status == STAT_NOT_CHARGING);
			is_dis  = (status == STAT_DISCHARGING || status == STAT_NOT_CHARGING);
			if (was_chg && is_dis) dir_change = 2;
			else if (was_dis && status == STAT_CHARGING) dir_change = 1;
			last_status = status;
		end
		// full point search on direction change while smoothing
		if (smooth_dir == 1 && dir_change == 2) begin
			t = full_pt;
			while (t <= FULL_POINT_MAX) begin
				if (scale_round(cap, t) <= last_shown) break;
				t++;
			end
			full_pt = (t > FULL_POINT_SAT) ? FULL_POINT_SAT : t;
		end else if (smooth_dir == 2 && dir_change == 1) begin
			lo = (cfg_full_limit < 1) ? 1 : cfg_full_limit;
			t = full_pt;
			hit = 0;
			while (t >= lo) begin
				if (scale_round(cap, t) >= last_shown) begin
					hit = 1;
					break;
				end
				t--;
			end
			if (!hit && t < 1) t = 1;
			full_pt = t;
		end
		if (smooth_dir == 0 && dir_change == 2 && last_shown == 100)
			full_pt = (full_pt > 1) ? full_pt - 1 : 1;
		newcap = (cap < full_pt) ? scale_round(cap, full_pt) : 100;
		if (newcap > 100) newcap = 100;
		if (last_shown == NONE_YET) last_shown = newcap;
		last = last_shown;
		delta = (newcap > last) ? newcap - last : last - newcap;
		// gauge period tracking
		if (now >= gauge_time)
			elapsed = (gauge_cap_seen != cap) ? now - gauge_time : now - step_stamp;
		else
			elapsed = 60;
		if (gauge_cap_seen != cap && status != STAT_FULL) begin
			if (gauge_cap_seen != NONE_YET && elapsed > 0) gauge_period = elapsed;
			if (gauge_period < MIN_PERIOD) gauge_period = MIN_PERIOD;
			gauge_cap_seen = cap;
			gauge_time = now;
		end
		if (status == STAT_DISCHARGING && newcap > last) return last;
		if (delta == 1) begin
			if (smooth_dir == 0) ret = newcap;
			else if (elapsed >= gauge_period / 2) begin
				smooth_dir = 0;
				ret = newcap;
			end else ret = last;
		end else if (delta > 1) begin
			if (smooth_dir == 0) begin
				smooth_dir = (newcap > last) ? 1 : 2;
				ret = (newcap > last) ? last + 1 : last - 1;
			end else if (elapsed >= gauge_period / 2)
				ret = (newcap > last) ? last + 1 : last - 1;
			else ret = last;
		end else begin
			smooth_dir = 0;
			ret = newcap;
		end
		if (ret > 100) ret = 100;
		if (last != ret) begin
			last_shown = ret;
			step_stamp = now;
		end
		return ret;
	endfunction

	// input beat acceptance feeds the model
	always @(posedge clk) begin
		int want;
		if (in_valid && in_ready) begin
			want = predict_shown(raw_capacity, charge_status, health_good, now_seconds);
			shown_q.push_back((typed_shown != NO_TYPED) ? typed_shown[6:0] : want[6:0]);
			in_beats++;
		end
	end

	// result beat check
	always @(posedge clk) begin
		logic [6:0] want;
		if (out_valid && out_ready) begin
			if (shown_q.size() == 0)
				report_mismatch("unexpected beat", shown_capacity, 0);
			else begin
				want = shown_q.pop_front();
				if (shown_capacity !== want)
					report_mismatch("shown_capacity", shown_capacity, want);
			end
		end
	end

	// watchdog on cycles with no progress
	always @(posedge clk) begin
		int stall;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			stall = 0;
		else stall++;
		if (stall == STALL_LIMIT) begin
			$display("timeout");
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 16) - 1) @(negedge clk);
			end else begin
				out_ready <= 1;
				repeat ($urandom_range(1, 24) - 1) @(negedge clk);
			end
		end
	end

	task automatic apb_write(input int idx, input int value);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= 3'(4 * idx); pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_FULL_LIMIT) cfg_full_limit = value & 8'h7f;
		else cfg_fake_en = value & 1;
	endtask

	// drive one report beat; called and returns at a falling edge
	task automatic send_report(input int cap, input int status, input int health,
			input bit [31:0] now, input int typed);
		int seen;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		raw_capacity <= cap; charge_status <= status;
		health_good <= health; now_seconds <= now;
		typed_shown = typed;
		in_valid <= 1;
		seen = in_beats;
		do @(negedge clk); while (in_beats == seen);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (shown_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	typedef struct {
		int        cap;
		int        status;
		int        health;
		bit [31:0] now;
		int        shown;
	} report_row_t;

	// directed rows: smoothing both ways, both searches, full-status drop, time edges
	report_row_t directed[] = '{
		'{49, STAT_DISCHARGING, 1, 100, 50},
		'{30, STAT_DISCHARGING, 1, 200, NO_TYPED},
		'{31, STAT_CHARGING, 1, 230, NO_TYPED},
		'{90, STAT_CHARGING, 1, 300, NO_TYPED},
		'{88, STAT_DISCHARGING, 1, 310, NO_TYPED},
		'{100, STAT_FULL, 1, 400, NO_TYPED},
		'{100, STAT_FULL, 1, 500, NO_TYPED},
		'{100, STAT_FULL, 1, 900, NO_TYPED},
		'{100, STAT_DISCHARGING, 1, 1000, NO_TYPED},
		'{127, STAT_UNKNOWN, 0, 1100, NO_TYPED},
		'{0, STAT_UNUSED_LO, 1, 1200, NO_TYPED},
		'{0, STAT_UNUSED_LO + 3'd1, 0, 0, NO_TYPED},
		'{50, STAT_UNUSED_HI, 1, 32'hFFFF_FFFF, NO_TYPED},
		'{51, STAT_NOT_CHARGING, 1, 10, NO_TYPED},
		'{99, STAT_FULL, 1, 20, NO_TYPED},
		'{98, STAT_NOT_CHARGING, 0, 2000, NO_TYPED},
		'{101, STAT_CHARGING, 1, 2100, NO_TYPED},
		'{64, STAT_CHARGING, 1, 32'h8000_0000, NO_TYPED}
	};

	int        limits[] = '{50, 100, 0, 127, FULL_LIMIT_RST};
	bit [31:0] clock_s;
	int        level, status;

	// mostly plausible gauge traces with random content, some noise
	task automatic random_report();
		int step;
		if ($urandom_range(0, 99) < 85) begin
			clock_s += $urandom_range(1, 150);
			step = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
			if ($urandom_range(0, 1)) level += step; else level -= step;
			if (level < 0) level = 0;
			if (level > 100) level = 100;
			if ($urandom_range(0, 7) == 0)
				status = (status == STAT_CHARGING || status == STAT_FULL) ?
					$urandom_range(STAT_DISCHARGING, STAT_NOT_CHARGING) : STAT_CHARGING;
			if (status == STAT_CHARGING && level >= 95 && $urandom_range(0, 1))
				status = STAT_FULL;
			send_report(level, status, $urandom_range(0, 9) != 0, clock_s, NO_TYPED);
		end else begin
			clock_s = $urandom();
			send_report($urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 1),
				clock_s, NO_TYPED);
		end
	endtask

	initial begin
		cfg_full_limit = FULL_LIMIT_RST; cfg_fake_en = 0;
		full_pt = FULL_POINT_RST; last_status = 0; smooth_dir = 0;
		gauge_cap_seen = NONE_YET; last_shown = NONE_YET;
		gauge_time = 0; gauge_period = MIN_PERIOD; step_stamp = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		foreach (directed[i])
			send_report(directed[i].cap, directed[i].status, directed[i].health,
				directed[i].now, directed[i].shown);
		drain();

		// pass-through mode
		apb_write(REG_FAKE_EN, 1);
		send_report(127, STAT_CHARGING, 1, 5000, 127);
		send_report(0, STAT_DISCHARGING, 0, 5001, 0);
		drain();
		apb_write(REG_FAKE_EN, 0);

		clock_s = 6000; level = 60; status = STAT_DISCHARGING;
		foreach (limits[p]) begin
			apb_write(REG_FULL_LIMIT, limits[p]);
			if (p == limits.size() - 1) calm = 1;
			for (int n = 0; n < 55; n++) begin
				if (p == 1 && n == 10) hold_req = 1;
				random_report();
			end
			drain();
		end

		repeat (50) @(negedge clk);
		if (errors == 0 && shown_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
